@@ rtl/ssg_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package ssg_pkg;

	localparam int DIMS  = 16;
	localparam int SLOTS = 1024;
	localparam int BITS  = 32;

	localparam int DIM_W   = 4;
	localparam int SLOT_W  = 10;
	localparam int BIT_W   = 5;
	localparam int DIR_AW  = DIM_W + BIT_W;
	localparam int SLOT_AW = DIM_W + SLOT_W;

	localparam logic [1:0] MODE_LOAD   = 2'd0;
	localparam logic [1:0] MODE_EXPAND = 2'd1;
	localparam logic [1:0] MODE_DRAW   = 2'd2;
	localparam logic [1:0] MODE_CLEAR  = 2'd3;

	// request into the direction unit
	typedef struct packed {
		logic              load;
		logic              expand;
		logic              rd;
		logic [DIM_W-1:0]  dim;
		logic [BIT_W-1:0]  idx;
		logic [BITS-1:0]   wdata;
		logic [BIT_W-1:0]  degree;
		logic [BITS-2:0]   poly;
	} dir_req_t;

	// request into the slot unit, read and write never in the same cycle
	typedef struct packed {
		logic               rd;
		logic               wr;
		logic [SLOT_AW-1:0] addr;
		logic [2*BITS-1:0]  wdata;
	} slot_req_t;

	// index of the lowest zero bit of c
	function automatic logic [BIT_W-1:0] lowest_zero(input logic [BITS-1:0] c);
		logic [BITS-1:0]  hot;
		logic [BIT_W-1:0] z;
		hot = ~c & (c + BITS'(1));
		z = '0;
		for (int b = 0; b < BIT_W; b++) begin
			for (int i = 0; i < BITS; i++) begin
				if (((i >> b) & 1) == 1)
					z[b] = z[b] | hot[i];
			end
		end
		return z;
	endfunction

endpackage
`default_nettype wire

@@ rtl/ssg_slot_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
module ssg_slot_unit (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire ssg_pkg::slot_req_t           req,
	output logic [2*ssg_pkg::BITS-1:0]        rdata,
	output logic                              init_busy
);

	localparam int DEPTH = ssg_pkg::DIMS * ssg_pkg::SLOTS;

	logic [2*ssg_pkg::BITS-1:0] mem [DEPTH];

	logic                        clr_q;
	logic [ssg_pkg::SLOT_AW-1:0] clr_addr_q;

	logic                        we;
	logic [ssg_pkg::SLOT_AW-1:0] wa;
	logic [2*ssg_pkg::BITS-1:0]  wd;

	// clearing pass after reset, one entry a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + ssg_pkg::SLOT_AW'(1);
			if (&clr_addr_q)
				clr_q <= 1'b0;
		end
	end

	always_comb begin
		we = clr_q | req.wr;
		wa = clr_q ? clr_addr_q : req.addr;
		wd = clr_q ? '0 : req.wdata;
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[wa] <= wd;
		if (req.rd)
			rdata <= mem[req.addr];
	end

	assign init_busy = clr_q;

endmodule
`default_nettype wire

@@ rtl/ssg_dir_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
module ssg_dir_unit (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire ssg_pkg::dir_req_t      req,
	output logic [ssg_pkg::BITS-1:0]    rdata,
	output logic                        busy
);

	localparam int DEPTH = ssg_pkg::DIMS * ssg_pkg::BITS;

	localparam logic [2:0] X_IDLE = 3'd0;
	localparam logic [2:0] X_ONE  = 3'd1;
	localparam logic [2:0] X_RD   = 3'd2;
	localparam logic [2:0] X_AC   = 3'd3;
	localparam logic [2:0] B_RD   = 3'd4;
	localparam logic [2:0] B_WR   = 3'd5;

	logic [ssg_pkg::BITS-1:0] mem [DEPTH];

	logic [2:0]                  st_q;
	logic [ssg_pkg::DIM_W-1:0]   dim_q;
	logic [ssg_pkg::BIT_W-1:0]   deg_q;
	logic [ssg_pkg::BITS-1:0]    poly_q;
	logic [ssg_pkg::BIT_W-1:0]   k_q;
	logic [ssg_pkg::BIT_W-1:0]   j_q;
	logic [ssg_pkg::BITS-1:0]    acc_q;

	logic                        last_term;
	logic [ssg_pkg::BIT_W-1:0]   pbit;
	logic [ssg_pkg::BITS-1:0]    shifted;
	logic [ssg_pkg::BITS-1:0]    acc_n;
	logic                        re;
	logic [ssg_pkg::DIR_AW-1:0]  ra;
	logic                        we;
	logic [ssg_pkg::DIR_AW-1:0]  wa;
	logic [ssg_pkg::BITS-1:0]    wd;

	// one recurrence term per read: m_(k-j) shifted by j, the lowest term adds m itself
	always_comb begin
		last_term = (j_q == deg_q);
		pbit      = deg_q - ssg_pkg::BIT_W'(1) - j_q;
		shifted   = rdata << j_q;
		if (last_term)
			acc_n = acc_q ^ rdata ^ shifted;
		else if (poly_q[pbit])
			acc_n = acc_q ^ shifted;
		else
			acc_n = acc_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= X_IDLE;
		end else begin
			case (st_q)
				X_IDLE: begin
					if (req.expand)
						st_q <= (req.degree == '0) ? X_ONE : X_RD;
				end
				X_ONE: begin
					if (&k_q)
						st_q <= B_RD;
				end
				X_RD: st_q <= X_AC;
				X_AC: begin
					if (last_term && (&k_q))
						st_q <= B_RD;
					else
						st_q <= X_RD;
				end
				B_RD: st_q <= B_WR;
				B_WR: begin
					if (&k_q)
						st_q <= X_IDLE;
					else
						st_q <= B_RD;
				end
				default: st_q <= X_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			X_IDLE: begin
				if (req.expand) begin
					dim_q  <= req.dim;
					deg_q  <= req.degree;
					poly_q <= {1'b0, req.poly};
					k_q    <= req.degree;
					j_q    <= ssg_pkg::BIT_W'(1);
					acc_q  <= '0;
				end
			end
			X_ONE: k_q <= k_q + ssg_pkg::BIT_W'(1);
			X_AC: begin
				if (last_term) begin
					k_q   <= k_q + ssg_pkg::BIT_W'(1);
					j_q   <= ssg_pkg::BIT_W'(1);
					acc_q <= '0;
				end else begin
					j_q   <= j_q + ssg_pkg::BIT_W'(1);
					acc_q <= acc_n;
				end
			end
			B_WR: k_q <= k_q + ssg_pkg::BIT_W'(1);
			default: ;
		endcase
	end

	// memory port selection
	always_comb begin
		re = req.rd || (st_q == X_RD) || (st_q == B_RD);
		if (req.rd)
			ra = {req.dim, req.idx};
		else if (st_q == B_RD)
			ra = {dim_q, k_q};
		else
			ra = {dim_q, k_q - j_q};

		we = req.load || (st_q == X_ONE) || ((st_q == X_AC) && last_term) || (st_q == B_WR);
		wa = req.load ? {req.dim, req.idx} : {dim_q, k_q};
		case (st_q)
			X_ONE:   wd = ssg_pkg::BITS'(1);
			X_AC:    wd = acc_n;
			B_WR:    wd = rdata << (~k_q);
			default: wd = req.wdata;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[wa] <= wd;
		if (re)
			rdata <= mem[ra];
	end

	assign busy = (st_q != X_IDLE);

endmodule
`default_nettype wire

@@ rtl/sobol_sequence_generator.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Sobol sequence generator, Gray-code form, 16 dimensions by 1024 slots. A request is taken
// when start is high and busy is low; every request gives exactly one result, shown on
// sample and exhausted for the single cycle that done is high. The receiver cannot stall:
// a result that is not taken in its cycle is gone. Load and clear show their result in the
// cycle after the request. A draw runs as a slot memory read of count and value, then a
// direction memory read at the lowest zero bit of the count, then write-back and result.
// Expand answers at once but keeps busy high while it walks the direction memory one read
// at a time, first for the recurrence of degree s and then to shift each entry into place.
// After reset busy stays high while the slot memory is cleared, one entry a cycle.
module sobol_sequence_generator (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	output logic        busy,
	input  wire  [1:0]  mode,
	input  wire  [3:0]  dim,
	input  wire  [9:0]  slot,
	input  wire  [4:0]  bit_pos,
	input  wire  [31:0] init_value,
	input  wire  [4:0]  degree,
	input  wire  [30:0] poly,
	output logic        done,
	output logic [31:0] sample,
	output logic        exhausted
);

	// draw sequencer
	localparam logic [1:0] T_IDLE = 2'd0;
	localparam logic [1:0] T_CNT  = 2'd1;  // count and value on the slot read port
	localparam logic [1:0] T_DIR  = 2'd2;  // direction number on the direction read port

	logic [1:0]                          st_q;
	logic [ssg_pkg::DIM_W-1:0]           dim_q;
	logic [ssg_pkg::SLOT_AW-1:0]         addr_q;
	logic [ssg_pkg::BITS-1:0]            cnt_s2;
	logic [ssg_pkg::BITS-1:0]            val_s2;
	logic                                done_q;
	logic [ssg_pkg::BITS-1:0]            sample_q;
	logic                                exhausted_q;

	logic                                accept;
	logic                                dir_busy;
	logic                                slot_busy;
	ssg_pkg::dir_req_t                   dir_req;
	ssg_pkg::slot_req_t                  slot_req;
	logic [ssg_pkg::BITS-1:0]            dir_rdata;
	logic [2*ssg_pkg::BITS-1:0]          slot_rdata;
	logic [ssg_pkg::BITS-1:0]            cnt_rd;
	logic [ssg_pkg::BITS-1:0]            val_rd;
	logic [ssg_pkg::BIT_W-1:0]           z;
	logic                                exh;
	logic [ssg_pkg::BITS-1:0]            val_new;

	assign busy   = (st_q != T_IDLE) || dir_busy || slot_busy;
	assign accept = start && !busy;

	// slot word is {count, value}
	assign cnt_rd  = slot_rdata[2*ssg_pkg::BITS-1:ssg_pkg::BITS];
	assign val_rd  = slot_rdata[ssg_pkg::BITS-1:0];
	assign z       = ssg_pkg::lowest_zero(cnt_rd);
	assign exh     = &cnt_s2;
	assign val_new = val_s2 ^ dir_rdata;

	always_comb begin
		dir_req.load   = accept && (mode == ssg_pkg::MODE_LOAD);
		dir_req.expand = accept && (mode == ssg_pkg::MODE_EXPAND);
		dir_req.rd     = (st_q == T_CNT);
		dir_req.dim    = (st_q == T_CNT) ? dim_q : dim;
		dir_req.idx    = (st_q == T_CNT) ? z : bit_pos;
		dir_req.wdata  = init_value;
		dir_req.degree = degree;
		dir_req.poly   = poly;
	end

	always_comb begin
		slot_req.rd = accept && (mode == ssg_pkg::MODE_DRAW);
		if (st_q == T_DIR) begin
			// draw write-back, skipped when the count is exhausted
			slot_req.wr    = !exh;
			slot_req.addr  = addr_q;
			slot_req.wdata = {cnt_s2 + ssg_pkg::BITS'(1), val_new};
		end else begin
			slot_req.wr    = accept && (mode == ssg_pkg::MODE_CLEAR);
			slot_req.addr  = {dim, slot};
			slot_req.wdata = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= T_IDLE;
			done_q      <= 1'b0;
			sample_q    <= '0;
			exhausted_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (st_q)
				T_IDLE: begin
					if (accept) begin
						if (mode == ssg_pkg::MODE_DRAW) begin
							st_q <= T_CNT;
						end else begin
							done_q      <= 1'b1;
							sample_q    <= '0;
							exhausted_q <= 1'b0;
						end
					end
				end
				T_CNT: st_q <= T_DIR;
				T_DIR: begin
					st_q        <= T_IDLE;
					done_q      <= 1'b1;
					sample_q    <= exh ? '0 : val_new;
					exhausted_q <= exh;
				end
				default: st_q <= T_IDLE;
			endcase
		end
	end

	// draw payload
	always_ff @(posedge clk) begin
		if (accept) begin
			dim_q  <= dim;
			addr_q <= {dim, slot};
		end
		if (st_q == T_CNT) begin
			cnt_s2 <= cnt_rd;
			val_s2 <= val_rd;
		end
	end

	ssg_dir_unit u_dir (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dir_req),
		.rdata  (dir_rdata),
		.busy   (dir_busy)
	);

	ssg_slot_unit u_slot (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (slot_req),
		.rdata     (slot_rdata),
		.init_busy (slot_busy)
	);

	assign done      = done_q;
	assign sample    = sample_q;
	assign exhausted = exhausted_q;

	// a result follows a non-draw request or the last draw step, nothing else
	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(accept && (mode != ssg_pkg::MODE_DRAW)) || $past(st_q == T_DIR)))
		else $error("result strobe without a matching request");

	// an exhausted draw returns a zero sample
	a_exh_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && exhausted) |-> (sample == '0))
		else $error("exhausted draw with nonzero sample");

	// an accepted draw moves into the count read step
	a_draw_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (mode == ssg_pkg::MODE_DRAW)) |=> (st_q == T_CNT && busy))
		else $error("draw request not sequenced");

endmodule
`default_nettype wire
